// ===== sv/lccp_pkg.sv =====
package lccp_pkg;

   // Core array size and field widths
   localparam int CORE_COUNT = 16;
   localparam int CORE_IDX_W = 4;
   localparam int LOAD_W     = 32;
   localparam int FREQ_W     = 32;
   localparam int COST_W     = 40;

   localparam logic [FREQ_W-1:0] Q16_UNIT   = 32'h0001_0000;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd78643;
   localparam logic [4:0]        ACTIVE_RESET = 5'd16;

   // Request kinds
   localparam logic [1:0] KIND_PICK  = 2'd0;
   localparam logic [1:0] KIND_SET   = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_ACTIVE_CORES   = 2'd0;
   localparam logic [1:0] CSR_THERMAL_LEVEL  = 2'd1;
   localparam logic [1:0] CSR_CORE_FREQUENCY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LAUNCH,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic                  clear;
      logic                  set_en;
      logic [CORE_IDX_W-1:0] set_idx;
      logic [LOAD_W-1:0]     set_value;
      logic                  inc_en;
      logic [CORE_IDX_W-1:0] inc_idx;
      logic [COST_W-1:0]     common;
      logic [4:0]            active_cores;
   } cell_ctl_type;

   // Running minimum handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  found;
      logic [COST_W-1:0]     cost;
      logic [CORE_IDX_W-1:0] idx;
   } token_type;

   // Thermal penalty: saturate at 100, then tens digit, by threshold count
   function automatic logic [3:0] heat_penalty(input logic [6:0] level);
      logic [3:0] pen;
      pen = 4'd0;
      for (int k = 1; k <= 10; k++) begin
         if (level >= 7'(10 * k)) begin
            pen = pen + 4'd1;
         end
      end
      return pen;
   endfunction

endpackage

// ===== sv/lccp_cell.sv =====
module lccp_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [3:0]             cell_idx,
   input  lccp_pkg::cell_ctl_type ctl,
   input  lccp_pkg::token_type    tok_i,
   output lccp_pkg::token_type    tok_o
);
   import lccp_pkg::*;

   logic [LOAD_W-1:0] load_ff;
   logic [LOAD_W-1:0] load_in;
   token_type         tok_ff;
   token_type         tok_in;
   logic [COST_W-1:0] load_ext;
   logic [COST_W-1:0] cost;
   logic              active;
   logic              take;

   // Score this core: shared term plus load times forty
   always_comb begin
      load_ext = {{(COST_W-LOAD_W){1'b0}}, load_ff};
      cost     = ctl.common + (load_ext << 5) + (load_ext << 3);
      active   = (cell_idx == '0) || ({1'b0, cell_idx} < ctl.active_cores);
      take     = active && (!tok_i.found || (cost < tok_i.cost));
   end

   // Pass the running minimum on; an active cell takes it over when none is found yet or on a strictly lower cost
   always_comb begin
      tok_in.valid = tok_i.valid;
      tok_in.found = tok_i.found | active;
      tok_in.cost  = take ? cost : tok_i.cost;
      tok_in.idx   = take ? cell_idx : tok_i.idx;
   end

   // Update the load counter
   always_comb begin
      load_in = load_ff;
      if (ctl.clear) begin
         load_in = '0;
      end else if (ctl.set_en && (ctl.set_idx == cell_idx)) begin
         load_in = ctl.set_value;
      end else if (ctl.inc_en && (ctl.inc_idx == cell_idx)) begin
         load_in = load_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         load_ff      <= load_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.found <= tok_in.found;
      tok_ff.cost  <= tok_in.cost;
      tok_ff.idx   <= tok_in.idx;
   end

   assign tok_o = tok_ff;

endmodule

// ===== sv/least_cost_core_picker.sv =====
// Least cost core picker. Holds a 32-bit load counter per core in a row of
// sixteen cells. A set or clear request takes effect at the edge that
// accepts it. A pick runs from acceptance to its result through these
// steps: form the cost term shared by all cores, launch into the first cell,
// then a running-minimum token moves one cell per cycle along the rest of
// the row, register the winner, and bump its load and fill the output
// register. The next request can be taken in the same cycle that the result
// appears. One pick is in flight at a time; a finished result waits in the
// output register while the next request is accepted, and a pick that finds
// that register still full holds in its last step until the result is taken.
// Configuration writes are taken every cycle.
module least_cost_core_picker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_task_frequency,
   input  logic [31:0] req_intensity,
   input  logic [3:0]  req_target_core,
   input  logic [31:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_chosen_core,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import lccp_pkg::*;

   state_type             state_ff, state_in;
   logic [4:0]            active_cores_ff;
   logic [6:0]            thermal_ff;
   logic [FREQ_W-1:0]     core_freq_ff;
   logic [FREQ_W-1:0]     err_ff, err_in;
   logic [31:0]           intensity_ff;
   logic [3:0]            penalty_ff;
   logic [COST_W-1:0]     common_ff, common_in;
   logic [CORE_IDX_W-1:0] best_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CORE_IDX_W-1:0] rsp_core_ff;
   logic                  req_beat;
   logic                  csr_beat;
   logic                  slot_free;
   logic                  launch;
   logic                  inc_en;
   logic [FREQ_W-1:0]     freq_sel;
   logic [COST_W-1:0]     int_ext;
   logic [COST_W-1:0]     pen_ext;
   cell_ctl_type          ctl;
   token_type             tok [0:CORE_COUNT];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_beat  = csr_valid && csr_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_cores_ff <= ACTIVE_RESET;
         thermal_ff      <= '0;
         core_freq_ff    <= FREQ_RESET;
      end else if (csr_beat) begin
         unique case (csr_index)
            CSR_ACTIVE_CORES:   active_cores_ff <= csr_data[4:0];
            CSR_THERMAL_LEVEL:  thermal_ff      <= csr_data[6:0];
            CSR_CORE_FREQUENCY: core_freq_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Frequency error of the request against the nominal frequency
   always_comb begin
      freq_sel = (req_task_frequency == '0) ? Q16_UNIT : req_task_frequency;
      err_in   = (freq_sel > core_freq_ff) ? (freq_sel - core_freq_ff)
                                           : (core_freq_ff - freq_sel);
   end

   // Shared cost term: frequency error bits 27:4, intensity times 25, penalty times 60
   always_comb begin
      int_ext   = {{(COST_W-32){1'b0}}, intensity_ff};
      pen_ext   = {{(COST_W-4){1'b0}}, penalty_ff};
      common_in = {{(COST_W-24){1'b0}}, err_ff[27:4]}
                + (int_ext << 4) + (int_ext << 3) + int_ext
                + (pen_ext << 6) - (pen_ext << 2);
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      launch       = 1'b0;
      inc_en       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat && (req_kind == KIND_PICK)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            launch   = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (tok[CORE_COUNT].valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               inc_en       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the pick operands and results
   always_ff @(posedge clock) begin
      if (req_beat) begin
         err_ff       <= err_in;
         intensity_ff <= req_intensity;
         penalty_ff   <= heat_penalty(thermal_ff);
      end
      if (state_ff == ST_PREP) begin
         common_ff <= common_in;
      end
      if ((state_ff == ST_SCAN) && tok[CORE_COUNT].valid) begin
         best_ff <= tok[CORE_COUNT].idx;
      end
      if (inc_en) begin
         rsp_core_ff <= best_ff;
      end
   end

   // Broadcast to the cells
   always_comb begin
      ctl.clear        = req_beat && (req_kind == KIND_CLEAR);
      ctl.set_en       = req_beat && (req_kind == KIND_SET);
      ctl.set_idx      = req_target_core;
      ctl.set_value    = req_load_value;
      ctl.inc_en       = inc_en;
      ctl.inc_idx      = best_ff;
      ctl.common       = common_ff;
      ctl.active_cores = active_cores_ff;
   end

   // Head of the row: an empty minimum
   always_comb begin
      tok[0].valid = launch;
      tok[0].found = 1'b0;
      tok[0].cost  = '0;
      tok[0].idx   = '0;
   end

   for (genvar g = 0; g < CORE_COUNT; g++) begin : g_cell
      lccp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (CORE_IDX_W'(g)),
         .ctl      (ctl),
         .tok_i    (tok[g]),
         .tok_o    (tok[g+1])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_core = rsp_core_ff;

endmodule
